FILE: rtl/core/crc32sh_pkg.sv
// ----------------------------------------------------------------------------
// crc32sh_pkg
// Shared types, constants and the on-the-fly CRC table entry function.
// ----------------------------------------------------------------------------
package crc32sh_pkg;

	localparam int unsigned HASH_W     = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CNT_W      = 3;

	localparam logic [HASH_W-1:0] POLY_RESET = 32'h04C1_1DB7;
	localparam logic [CNT_W-1:0]  CNT_EMPTY  = 3'd0;
	localparam logic [CNT_W-1:0]  CNT_ONE    = 3'd1;
	localparam logic [CNT_W-1:0]  CNT_TWO    = 3'd2;
	localparam logic [CNT_W-1:0]  CNT_THREE  = 3'd3;
	localparam logic [CNT_W-1:0]  CNT_FULL   = 3'd4;

	// one input request
	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              last;
		logic              empty_req;
	} item_t;

	// entry for a top byte: byte at bit 24, eight MSB-first division steps
	function automatic logic [HASH_W-1:0] table_entry(
		input logic [BYTE_W-1:0] top,
		input logic [HASH_W-1:0] poly
	);
		logic [HASH_W-1:0] r;
		r = {top, 24'h0};
		for (int k = 0; k < 8; k++) begin
			if (r[HASH_W-1]) begin
				r = {r[HASH_W-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[HASH_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/crc32_string_hash.sv
// ----------------------------------------------------------------------------
// crc32_string_hash
// MSB-first augmented CRC-32 hash of a byte string, one byte per request.
// ----------------------------------------------------------------------------
// Path: a last (or empty) request is captured by the input register, and its
//   hash by the result register once that register can take it.
// Throughput: one request per cycle unless a finished hash is stuck; byte
//   update and table entry are one combinational pass, input to state regs.
// Reset: arst_n clears all control and hash state; polynomial -> 0x04C11DB7.
// ----------------------------------------------------------------------------
module crc32_string_hash (
	input  logic                           clk,
	input  logic                           arst_n,
	// polynomial register write
	input  logic                           poly_wr_en,
	input  logic [crc32sh_pkg::HASH_W-1:0] poly_wr_data,
	// byte requests
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [crc32sh_pkg::BYTE_W-1:0] byte_value,
	input  logic                           last,
	input  logic                           empty_req,
	// hash results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [crc32sh_pkg::HASH_W-1:0] hash_value
);

	crc32sh_pkg::item_t             in_item;
	crc32sh_pkg::item_t             item_s1;
	logic                           valid_s1;
	logic                           take;
	logic                           out_free;
	logic                           res_valid;
	logic [crc32sh_pkg::HASH_W-1:0] res_hash;

	assign in_item.byte_value = byte_value;
	assign in_item.last       = last;
	assign in_item.empty_req  = empty_req;

	// Input register. A request moves on whenever the core takes it, so a
	// new byte is accepted every cycle unless a finished hash is stuck.
	crc32sh_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Hash state: first byte loads the top, bytes 1..3 pack below it until
	// a zero byte, then invert; later bytes shift in and XOR the table entry
	// of the old top byte. A zero byte after byte 0 freezes the hash until
	// the string ends. A request that ends a string only goes when the
	// result register can take its hash.
	crc32sh_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.poly_wr_en   (poly_wr_en),
		.poly_wr_data (poly_wr_data),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.out_free     (out_free),
		.take         (take),
		.res_valid    (res_valid),
		.res_hash     (res_hash)
	);

	// Result register, parting the consumer from the hash pipeline.
	crc32sh_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_hash   (res_hash),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

endmodule

FILE: rtl/core/crc32sh_in_stage.sv
// ----------------------------------------------------------------------------
// crc32sh_in_stage
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
module crc32sh_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  crc32sh_pkg::item_t  in_item,
	input  logic                take,
	output logic                valid_s1,
	output crc32sh_pkg::item_t  item_s1
);

	logic vld_s1;

	assign in_ready = !vld_s1 || take;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/core/crc32sh_core.sv
// ----------------------------------------------------------------------------
// crc32sh_core
// Hash state, polynomial register and the per-byte update.
// ----------------------------------------------------------------------------
module crc32sh_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 poly_wr_en,
	input  logic [crc32sh_pkg::HASH_W-1:0]       poly_wr_data,
	input  logic                                 valid_s1,
	input  crc32sh_pkg::item_t                   item_s1,
	input  logic                                 out_free,
	output logic                                 take,
	output logic                                 res_valid,
	output logic [crc32sh_pkg::HASH_W-1:0]       res_hash
);

	logic [crc32sh_pkg::HASH_W-1:0] poly_q;
	logic [crc32sh_pkg::HASH_W-1:0] acc_q, acc_n, acc_upd;
	logic [crc32sh_pkg::CNT_W-1:0]  cnt_q, cnt_n, cnt_upd;
	logic                           stop_q, stop_n, stop_upd;
	logic                           ends;
	logic                           zero_byte;

	assign ends      = item_s1.last || item_s1.empty_req;
	assign take      = valid_s1 && (!ends || out_free);
	assign res_valid = take && ends;
	assign zero_byte = (item_s1.byte_value == '0);

	// byte update, ignoring string end
	always_comb begin
		acc_upd  = acc_q;
		cnt_upd  = cnt_q;
		stop_upd = stop_q;
		if (!stop_q) begin
			unique case (cnt_q)
				crc32sh_pkg::CNT_EMPTY: begin
					acc_upd = {item_s1.byte_value, 24'h0};
					cnt_upd = crc32sh_pkg::CNT_ONE;
				end
				crc32sh_pkg::CNT_ONE: begin
					if (zero_byte) begin
						stop_upd = 1'b1;
					end else begin
						acc_upd = acc_q | {8'h0, item_s1.byte_value, 16'h0};
						cnt_upd = crc32sh_pkg::CNT_TWO;
					end
				end
				crc32sh_pkg::CNT_TWO: begin
					if (zero_byte) begin
						stop_upd = 1'b1;
					end else begin
						acc_upd = acc_q | {16'h0, item_s1.byte_value, 8'h0};
						cnt_upd = crc32sh_pkg::CNT_THREE;
					end
				end
				crc32sh_pkg::CNT_THREE: begin
					if (zero_byte) begin
						stop_upd = 1'b1;
					end else begin
						// fourth byte packed: invert the register
						acc_upd = ~(acc_q | {24'h0, item_s1.byte_value});
						cnt_upd = crc32sh_pkg::CNT_FULL;
					end
				end
				default: begin
					if (zero_byte) begin
						stop_upd = 1'b1;
					end else begin
						acc_upd = {acc_q[23:0], item_s1.byte_value}
							^ crc32sh_pkg::table_entry(acc_q[31:24], poly_q);
					end
				end
			endcase
		end
	end

	always_comb begin
		if (item_s1.empty_req) begin
			res_hash = '0;
		end else if (cnt_upd == crc32sh_pkg::CNT_FULL) begin
			res_hash = ~acc_upd;
		end else begin
			res_hash = acc_upd;
		end
		if (ends) begin
			acc_n  = '0;
			cnt_n  = crc32sh_pkg::CNT_EMPTY;
			stop_n = 1'b0;
		end else begin
			acc_n  = acc_upd;
			cnt_n  = cnt_upd;
			stop_n = stop_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= crc32sh_pkg::POLY_RESET;
			acc_q  <= '0;
			cnt_q  <= crc32sh_pkg::CNT_EMPTY;
			stop_q <= 1'b0;
		end else begin
			if (poly_wr_en) begin
				poly_q <= poly_wr_data;
			end
			if (take) begin
				acc_q  <= acc_n;
				cnt_q  <= cnt_n;
				stop_q <= stop_n;
			end
		end
	end

endmodule

FILE: rtl/core/crc32sh_out_reg.sv
// ----------------------------------------------------------------------------
// crc32sh_out_reg
// Result register: holds a finished hash until the consumer takes it.
// ----------------------------------------------------------------------------
module crc32sh_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_valid,
	input  logic [crc32sh_pkg::HASH_W-1:0] res_hash,
	output logic                           out_free,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [crc32sh_pkg::HASH_W-1:0] hash_value
);

	logic                           vld_q;
	logic [crc32sh_pkg::HASH_W-1:0] hash_q;

	assign out_free   = !vld_q || out_ready;
	assign out_valid  = vld_q;
	assign hash_value = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			hash_q <= res_hash;
		end
	end

endmodule

FILE: tb/sv/tb_crc32_string_hash.sv
// ----------------------------------------------------------------------------
// tb_crc32_string_hash
// Self-checking bench for the MSB-first augmented CRC-32 string hash. Byte
// requests go in over valid/ready with random bursts and gaps, the hash port
// stalls on its own pattern, and every hash is compared with a local
// prediction built from the request stream and the current polynomial.
// ----------------------------------------------------------------------------
module tb_crc32_string_hash;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HASH_W = crc32sh_pkg::HASH_W;
	localparam int unsigned BYTE_W = crc32sh_pkg::BYTE_W;
	localparam int unsigned CNT_W  = crc32sh_pkg::CNT_W;

	// A hash passes the input and result registers after its final request is
	// accepted; leave margin before polynomial writes and at the end, since
	// non-last bytes have no result.
	localparam int unsigned FLUSH_CYCLES  = 4;
	localparam int unsigned RANDOM_ITEMS  = 850;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned MAX_GAP       = 6;
	localparam int unsigned MAX_BURST     = 12;

	// receiver behavior, re-picked each time the stall tick wraps
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_PATTERN,
		RX_HEAVY
	} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              poly_wr_en;
	logic [HASH_W-1:0] poly_wr_data;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] byte_value;
	logic              last;
	logic              empty_req;
	logic              out_valid;
	logic              out_ready;
	logic [HASH_W-1:0] hash_value;

	// predictor state: polynomial copy and the string being hashed
	logic [HASH_W-1:0] poly_shadow;
	logic [HASH_W-1:0] crc_acc;
	logic [CNT_W-1:0]  packed_count;
	bit                hash_stopped;

	logic [HASH_W-1:0] pending_hashes[$];
	logic [HASH_W-1:0] expected_hash;
	int unsigned       error_count;
	int unsigned       items_sent;

	// sender pacing
	bit                gaps_on;
	int unsigned       burst_left;

	// receiver stall pattern
	rx_mode_t          rx_mode;
	logic [31:0]       stall_pattern;
	logic [5:0]        stall_tick;

	crc32_string_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poly_wr_en   (poly_wr_en),
		.poly_wr_data (poly_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last         (last),
		.empty_req    (empty_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// CRC table entry for one top byte: byte at the top of the word, then
	// eight shift/conditional-XOR division steps by the polynomial
	function automatic logic [HASH_W-1:0] divide_top_byte(
		input logic [BYTE_W-1:0] top,
		input logic [HASH_W-1:0] poly
	);
		logic [HASH_W-1:0] rem;
		rem = HASH_W'(top) << (HASH_W - BYTE_W);
		repeat (BYTE_W)
			rem = {rem[HASH_W-2:0], 1'b0} ^ (poly & {HASH_W{rem[HASH_W-1]}});
		return rem;
	endfunction

	task automatic clear_string_state();
		crc_acc      = '0;
		packed_count = crc32sh_pkg::CNT_EMPTY;
		hash_stopped = 1'b0;
	endtask

	// advance the string state by one accepted request; queue the hash on
	// a final or empty request
	task automatic hash_request(
		input logic [BYTE_W-1:0] b,
		input logic              lst,
		input logic              emp
	);
		int unsigned shift;
		if (emp) begin
			// empty request: hash 0 regardless of last, state cleared
			pending_hashes.push_back('0);
			clear_string_state();
		end else begin
			if (!hash_stopped) begin
				if (packed_count == crc32sh_pkg::CNT_EMPTY) begin
					// first byte always loads, even a zero
					crc_acc      = HASH_W'(b) << (HASH_W - BYTE_W);
					packed_count = crc32sh_pkg::CNT_ONE;
				end else if (b == '0) begin
					// later zero byte terminates hashing
					hash_stopped = 1'b1;
				end else if (packed_count != crc32sh_pkg::CNT_FULL) begin
					shift        = HASH_W - BYTE_W * (packed_count + 1);
					crc_acc      = crc_acc | (HASH_W'(b) << shift);
					packed_count = packed_count + 1'b1;
					if (packed_count == crc32sh_pkg::CNT_FULL)
						crc_acc = ~crc_acc;
				end else begin
					crc_acc = {crc_acc[HASH_W-BYTE_W-1:0], b}
						^ divide_top_byte(crc_acc[HASH_W-1 -: BYTE_W], poly_shadow);
				end
			end
			if (lst) begin
				// short strings are never inverted; full ones get inverted back on output
				pending_hashes.push_back((packed_count == crc32sh_pkg::CNT_FULL)
					? ~crc_acc : crc_acc);
				clear_string_state();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// bursts of random length, random gaps between them when enabled
	task automatic pace_sender();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			end
			burst_left = $urandom_range(1, MAX_BURST);
		end
	endtask

	// present one request, hold it until accepted, then predict
	task automatic send_request(
		input logic [BYTE_W-1:0] b,
		input logic              lst,
		input logic              emp
	);
		in_valid   <= 1'b1;
		byte_value <= b;
		last       <= lst;
		empty_req  <= emp;
		do
			@(posedge clk);
		while (!in_ready);
		hash_request(b, lst, emp);
		items_sent++;
		pace_sender();
	endtask

	// one string of len bytes, last on the final one; zero bytes appear
	// with odds 1/zero_odds (0 = never)
	task automatic send_string(input int unsigned len, input int unsigned zero_odds);
		logic [BYTE_W-1:0] b;
		for (int unsigned i = 0; i < len; i++) begin
			if (zero_odds != 0 && $urandom_range(0, zero_odds - 1) == 0)
				b = '0;
			else
				b = BYTE_W'($urandom_range(1, 255));
			send_request(b, i == len - 1, 1'b0);
		end
	endtask

	// write the polynomial only once the block has drained
	task automatic set_polynomial(input logic [HASH_W-1:0] p);
		in_valid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		poly_wr_en   <= 1'b1;
		poly_wr_data <= p;
		@(posedge clk);
		poly_wr_en   <= 1'b0;
		poly_shadow  = p;
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		if (stall_tick == 0) begin
			stall_pattern = $urandom;
			rx_mode       = rx_mode_t'($urandom_range(0, 2));
		end
		case (rx_mode)
			RX_OPEN:    out_ready <= 1'b1;
			RX_PATTERN: out_ready <= stall_pattern[stall_tick[4:0]];
			default:    out_ready <= stall_pattern[stall_tick[4:0]]
				& stall_pattern[stall_tick[4:0] ^ 5'd7];
		endcase
		stall_tick = stall_tick + 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_hashes.size() == 0) begin
				$display("%0t: hash with none pending: expected none, actual %08h",
					$time, hash_value);
				error_count++;
			end else begin
				expected_hash = pending_hashes.pop_front();
				if (hash_value !== expected_hash) begin
					$display("%0t: hash_value mismatch: expected %08h, actual %08h",
						$time, expected_hash, hash_value);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// corner strings with the reset polynomial
	task automatic test_directed_strings();
		gaps_on = 1'b1;
		send_request(8'h00, 1'b1, 1'b0);         // lone zero first byte
		send_request(8'h41, 1'b0, 1'b0);         // two-byte short string
		send_request(8'h42, 1'b1, 1'b0);
		repeat (3) send_request(8'hFF, 1'b0, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);         // exactly four bytes
		send_request(8'h01, 1'b0, 1'b0);         // long string, CRC steps
		send_request(8'h80, 1'b0, 1'b0);
		send_request(8'h7F, 1'b0, 1'b0);
		send_request(8'hFE, 1'b0, 1'b0);
		send_request(8'hAA, 1'b1, 1'b0);
		send_request(8'h12, 1'b0, 1'b0);         // zero stops early bytes
		send_request(8'h00, 1'b0, 1'b0);
		send_request(8'h34, 1'b0, 1'b0);
		send_request(8'h56, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b0);         // zero first, zero second
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'h11, 1'b0, 1'b0);         // empty aborts a partial string
		send_request(8'h22, 1'b0, 1'b0);
		send_request(8'hFF, 1'b0, 1'b1);         // empty without last
		send_request(8'h00, 1'b1, 1'b1);         // empty with last
		send_request(8'h33, 1'b0, 1'b0);
		send_request(8'h44, 1'b1, 1'b0);
	endtask

	// polynomial corners, long strings so the table is exercised
	task automatic test_polynomial_extremes();
		set_polynomial('0);
		send_string(9, 0);
		set_polynomial('1);
		send_string(9, 0);
		set_polynomial($urandom);
		send_string(7, 0);
	endtask

	// mostly well-formed strings with random bytes, some noise and empties
	task automatic test_random_strings();
		logic [HASH_W-1:0] poly;
		int unsigned       target;
		int unsigned       kind;
		int unsigned       len;
		for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       poly = crc32sh_pkg::POLY_RESET;
				1:       poly = '0;
				2:       poly = '1;
				3:       poly = 32'h1EDC_6F41;
				default: poly = $urandom;
			endcase
			set_polynomial(poly);
			gaps_on = ($urandom_range(0, 3) != 0);
			target  = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
			while (items_sent < target) begin
				kind = $urandom_range(0, 15);
				if (kind == 0) begin
					send_request(BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'b1);
				end else if (kind == 1) begin
					// noise: any byte, stray last and empty flags
					repeat ($urandom_range(1, 6))
						send_request(BYTE_W'($urandom_range(0, 255)),
							$urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
					send_request(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
				end else begin
					len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8)
						: $urandom_range(9, 40);
					send_string(len, 20);
				end
			end
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		poly_wr_en   <= 1'b0;
		poly_wr_data <= '0;
		in_valid     <= 1'b0;
		byte_value   <= '0;
		last         <= 1'b0;
		empty_req    <= 1'b0;
		out_ready    <= 1'b0;
		stall_tick    = '0;
		stall_pattern = '0;
		rx_mode       = RX_OPEN;
		error_count   = 0;
		items_sent    = 0;
		burst_left    = 1;
		gaps_on       = 1'b0;
		poly_shadow   = crc32sh_pkg::POLY_RESET;
		clear_string_state();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_strings();
		test_polynomial_extremes();
		test_random_strings();

		in_valid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (2 * FLUSH_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_hashes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
